// File: design/dvru_pkg.sv
// ----------------------------------------------------------------------------
// Distance-vector route update package
// Shared constants, status codes and the controller/datapath handshake types.
// ----------------------------------------------------------------------------
`default_nettype none

package dvru_pkg;

  // Default number of route table slots.
  localparam int unsigned TableDepthDef = 64;

  // Fixed field widths of one item and one result.
  localparam int unsigned AddrW   = 32;
  localparam int unsigned DistW   = 8;
  localparam int unsigned StatusW = 3;
  localparam int unsigned IndexW  = 6;

  // Result status codes.
  localparam logic [StatusW-1:0] StRefresh = 3'd0;
  localparam logic [StatusW-1:0] StBetter  = 3'd1;
  localparam logic [StatusW-1:0] StKept    = 3'd2;
  localparam logic [StatusW-1:0] StInsert  = 3'd3;
  localparam logic [StatusW-1:0] StFull    = 3'd4;

  // Largest distance; the added hop saturates here.
  localparam logic [DistW-1:0] DistMax = 8'hFF;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture a new item and restart the scan
    logic scan;    // advance the table scan by one slot
    logic finish;  // apply the update and present the result
  } dvru_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic match;      // the slot just read holds the destination
    logic exhausted;  // every valid slot was read without a match
  } dvru_sts_t;

endpackage : dvru_pkg

`default_nettype wire

// File: design/dvru_ctrl.sv
// ----------------------------------------------------------------------------
// Route update controller
// Sequences load, table scan and finish for one item at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module dvru_ctrl
  import dvru_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      start_i,
  input  wire dvru_sts_t sts_i,
  output dvru_cmd_t      cmd_o,
  output logic           busy_o
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_FINISH = 2'd2;

  logic [1:0] state_q, state_d;

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (start_i) state_d = S_SCAN;
      end
      S_SCAN: begin
        if (sts_i.match || sts_i.exhausted) state_d = S_FINISH;
      end
      S_FINISH: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Commands to the datapath.
  always_comb begin
    cmd_o.load   = (state_q == S_IDLE) && start_i;
    cmd_o.scan   = (state_q == S_SCAN) && !sts_i.match && !sts_i.exhausted;
    cmd_o.finish = (state_q == S_FINISH);
  end

  assign busy_o = (state_q != S_IDLE);

endmodule : dvru_ctrl

`default_nettype wire

// File: design/dvru_datapath.sv
// ----------------------------------------------------------------------------
// Route update datapath
// Holds the route table memory, the scan pointer and the result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module dvru_datapath
  import dvru_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = TableDepthDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire dvru_cmd_t          cmd_i,
  output dvru_sts_t               sts_o,
  input  wire logic [AddrW-1:0]   dest_network_i,
  input  wire logic [DistW-1:0]   advertised_distance_i,
  input  wire logic [AddrW-1:0]   sender_address_i,
  output logic                    done_o,
  output logic [StatusW-1:0]      status_o,
  output logic [IndexW-1:0]       entry_index_o,
  output logic [DistW-1:0]        route_distance_o,
  output logic [AddrW-1:0]        route_next_hop_o
);

  localparam int unsigned IdxW  = $clog2(TABLE_DEPTH);
  localparam int unsigned CntW  = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned WordW = 2 * AddrW + DistW;
  localparam logic [CntW-1:0] CntFull = CntW'(TABLE_DEPTH);

  // Route table: {destination, distance, next hop} per slot.
  logic [WordW-1:0] mem [TABLE_DEPTH];

  logic [CntW-1:0]  count_q;
  logic [CntW-1:0]  ptr_q;
  logic [IdxW-1:0]  slot_q;
  logic             rd_vld_q;
  logic [WordW-1:0] rd_data_q;

  logic [AddrW-1:0] dest_q;
  logic [AddrW-1:0] sender_q;
  logic [DistW-1:0] dist_q;

  logic [AddrW-1:0] rd_dest;
  logic [DistW-1:0] rd_dist;
  logic [AddrW-1:0] rd_hop;
  logic             match;
  logic             rd_en;
  logic             full;

  logic             wr_en;
  logic [IdxW-1:0]  wr_addr;
  logic [StatusW-1:0] res_status;
  logic [IdxW-1:0]  res_index;
  logic [DistW-1:0] res_dist;
  logic [AddrW-1:0] res_hop;
  logic [IdxW+IndexW-1:0] index_ext;

  assign rd_dest = rd_data_q[WordW-1 -: AddrW];
  assign rd_dist = rd_data_q[AddrW +: DistW];
  assign rd_hop  = rd_data_q[AddrW-1:0];

  assign match = rd_vld_q && (rd_dest == dest_q);
  assign full  = (count_q == CntFull);
  assign rd_en = cmd_i.scan && (ptr_q < count_q);

  assign sts_o.match     = match;
  assign sts_o.exhausted = !rd_vld_q && (ptr_q == count_q);

  // Item capture; the added hop saturates at the largest distance.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      dest_q   <= dest_network_i;
      sender_q <= sender_address_i;
      dist_q   <= (advertised_distance_i == DistMax) ? DistMax
                                                     : advertised_distance_i + 8'd1;
    end
  end

  // Scan pointer and read-in-flight flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q    <= '0;
      rd_vld_q <= 1'b0;
    end else if (cmd_i.load) begin
      ptr_q    <= '0;
      rd_vld_q <= 1'b0;
    end else if (cmd_i.scan) begin
      rd_vld_q <= rd_en;
      if (rd_en) ptr_q <= ptr_q + 1'b1;
    end
  end

  // Table memory: registered read at the scan pointer, one write port.
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= mem[ptr_q[IdxW-1:0]];
      slot_q    <= ptr_q[IdxW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= {dest_q, res_dist, res_hop};
    end
  end

  // Update decision for the matched slot or the next free slot; no write when full.
  always_comb begin
    wr_en      = 1'b0;
    wr_addr    = slot_q;
    res_index  = slot_q;
    res_status = StKept;
    res_dist   = rd_dist;
    res_hop    = rd_hop;
    if (match) begin
      if (rd_hop == sender_q) begin
        res_status = StRefresh;
        res_dist   = dist_q;
        wr_en      = cmd_i.finish;
      end else if (dist_q < rd_dist) begin
        res_status = StBetter;
        res_dist   = dist_q;
        res_hop    = sender_q;
        wr_en      = cmd_i.finish;
      end
    end else if (full) begin
      res_status = StFull;
      res_index  = '0;
      res_dist   = '0;
      res_hop    = '0;
    end else begin
      res_status = StInsert;
      res_index  = count_q[IdxW-1:0];
      res_dist   = dist_q;
      res_hop    = sender_q;
      wr_addr    = count_q[IdxW-1:0];
      wr_en      = cmd_i.finish;
    end
  end

  // Entry count grows on each insert.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.finish && !match && !full) begin
      count_q <= count_q + 1'b1;
    end
  end

  // The slot number is reported in its low bits only.
  assign index_ext = {{IndexW{1'b0}}, res_index};

  // Result registers and strobe.
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      status_o         <= res_status;
      entry_index_o    <= index_ext[IndexW-1:0];
      route_distance_o <= res_dist;
      route_next_hop_o <= res_hop;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= cmd_i.finish;
    end
  end

endmodule : dvru_datapath

`default_nettype wire

// File: design/distance_vector_route_update.sv
// ----------------------------------------------------------------------------
// Distance-vector route update
// Adds one hop to an advertised route and merges it into a route table.
//
//   Channel  Signals                                        Handshake
//   input    dest_network_i advertised_distance_i           start_i && !busy_o
//            sender_address_i
//   result   status_o entry_index_o route_distance_o        done_o, one cycle
//            route_next_hop_o
//
// On a match an item scans the table up to the matched slot and then finishes.
// A miss reads every valid slot, takes one more scan step to see that no slot
// is left, and then finishes; on an empty table the scan goes straight to
// finish. The scan reads the table memory one slot per cycle. busy_o falls in
// the cycle the result is shown, so the next item can be accepted at that
// edge. Reset empties the table at once through the entry count. The receiver
// cannot stall the result.
// ----------------------------------------------------------------------------
`default_nettype none

module distance_vector_route_update
  import dvru_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = TableDepthDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  output logic                    busy_o,
  input  wire logic [AddrW-1:0]   dest_network_i,
  input  wire logic [DistW-1:0]   advertised_distance_i,
  input  wire logic [AddrW-1:0]   sender_address_i,
  output logic                    done_o,
  output logic [StatusW-1:0]      status_o,
  output logic [IndexW-1:0]       entry_index_o,
  output logic [DistW-1:0]        route_distance_o,
  output logic [AddrW-1:0]        route_next_hop_o
);

  dvru_cmd_t cmd;
  dvru_sts_t sts;

  // Sequencer for load, scan and finish.
  dvru_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy_o)
  );

  // Table memory, compare and result registers.
  dvru_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cmd_i                 (cmd),
    .sts_o                 (sts),
    .dest_network_i        (dest_network_i),
    .advertised_distance_i (advertised_distance_i),
    .sender_address_i      (sender_address_i),
    .done_o                (done_o),
    .status_o              (status_o),
    .entry_index_o         (entry_index_o),
    .route_distance_o      (route_distance_o),
    .route_next_hop_o      (route_next_hop_o)
  );

endmodule : distance_vector_route_update

`default_nettype wire
